// ----- sv/asfdpp_pkg.sv -----
// Shared types and constants for the ASF data packet parser.
`default_nettype none

package asfdpp_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [4:0] {
        PH_FIRST   = 5'd0,
        PH_ECC     = 5'd1,
        PH_FLAGS   = 5'd2,
        PH_PROP    = 5'd3,
        PH_PLEN    = 5'd4,
        PH_SEQ     = 5'd5,
        PH_PAD     = 5'd6,
        PH_SEND    = 5'd7,
        PH_DUR     = 5'd8,
        PH_SEGTYPE = 5'd9,
        PH_SEG_NUM = 5'd10,
        PH_OBJNUM  = 5'd11,
        PH_OFFSET  = 5'd12,
        PH_REPLSZ  = 5'd13,
        PH_REPL    = 5'd14,
        PH_DELTA   = 5'd15,
        PH_FRAGSZ  = 5'd16,
        PH_DATA    = 5'd17,
        PH_SKIP    = 5'd18
    } t_phase;

    typedef enum logic [1:0] {
        MODE_SKIP   = 2'd0,
        MODE_FWD    = 2'd1,
        MODE_SUBLEN = 2'd2,
        MODE_SUB    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_DROP    = 2'd1,
        EV_ERROR   = 2'd2,
        EV_END     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        CFG_DEFAULT_PACKET_BYTES = 2'd0,
        CFG_AUDIO_STREAM         = 2'd1,
        CFG_TOTAL_PACKETS        = 2'd2,
        CFG_MAX_FRAME_BYTES      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] default_packet_bytes;
        logic [6:0]  audio_stream;
        logic [31:0] total_packets;
        logic [15:0] max_frame_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        t_event     event_res;
        logic       object_start;
        logic       object_end;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/asfdpp_cfg.sv -----
// Configuration register bank.
`default_nettype none

module asfdpp_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_we,
    input  wire logic [1:0]   i_addr,
    input  wire logic [31:0]  i_wdata,
    output asfdpp_pkg::t_cfg  o_cfg
);
    import asfdpp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_packet_bytes <= 16'd0;
            r_cfg.audio_stream         <= 7'd0;
            r_cfg.total_packets        <= 32'd0;
            r_cfg.max_frame_bytes      <= 16'hFFFF;
        end else if (i_we) begin
            case (t_cfg_idx'(i_addr))
                CFG_DEFAULT_PACKET_BYTES: r_cfg.default_packet_bytes <= i_wdata[15:0];
                CFG_AUDIO_STREAM:         r_cfg.audio_stream         <= i_wdata[6:0];
                CFG_TOTAL_PACKETS:        r_cfg.total_packets        <= i_wdata;
                CFG_MAX_FRAME_BYTES:      r_cfg.max_frame_bytes      <= i_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/asfdpp_core.sv -----
// Byte parser: parse state registers and the per-byte next-state logic.
`default_nettype none

module asfdpp_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  asfdpp_pkg::t_cfg    i_cfg,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    output logic                o_res_valid,
    output asfdpp_pkg::t_result o_res
);
    import asfdpp_pkg::*;

    typedef struct packed {
        t_phase           phase;
        logic [LEN_W-1:0] pkt_cnt;
        logic [LEN_W-1:0] pkt_len;
        logic [31:0]      pad_len;
        logic [LEN_W:0]   hdr_used;
        logic [1:0]       fld_idx;
        logic [2:0]       fld_left;
        logic [31:0]      fld_val;
        logic [7:0]       flags;
        logic [7:0]       prop;
        logic [7:0]       seg_type;
        logic [5:0]       segs_left;
        logic [LEN_W-1:0] size_left;
        logic [31:0]      pkts_done;
        logic [31:0]      frag_off;
        logic [31:0]      repl_size;
        logic [LEN_W-1:0] frag_left;
        logic [15:0]      obj_size;
        logic [15:0]      obj_filled;
        logic             obj_active;
        t_mode            mode;
        logic             halted;
        logic [6:0]       seg_stream;
        logic [31:0]      media_size;
        logic [7:0]       sub_left;
        logic             sub_first;
    } t_state;

    typedef struct packed {
        t_state  st;
        logic    emit;
        t_result res;
        logic    go;
        t_phase  gph;
    } t_work;

    t_state r_st;
    t_work  w;
    logic   in_payload;

    function automatic logic [2:0] sel_w(logic [1:0] s);
        return (s == 2'd3) ? 3'd4 : {1'b0, s};
    endfunction

    function automatic logic is_field(t_phase ph);
        case (ph)
            PH_PLEN, PH_SEQ, PH_PAD, PH_SEND, PH_DUR,
            PH_OBJNUM, PH_OFFSET, PH_REPLSZ, PH_FRAGSZ: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] fwidth(t_state s, t_phase ph);
        case (ph)
            PH_PLEN:   return sel_w(s.flags[6:5]);
            PH_SEQ:    return sel_w(s.flags[2:1]);
            PH_PAD:    return sel_w(s.flags[4:3]);
            PH_SEND:   return 3'd4;
            PH_DUR:    return 3'd2;
            PH_OBJNUM: return sel_w(s.prop[5:4]);
            PH_OFFSET: return sel_w(s.prop[3:2]);
            PH_REPLSZ: return sel_w(s.prop[1:0]);
            PH_FRAGSZ: return sel_w(s.seg_type[7:6]);
            default:   return 3'd0;
        endcase
    endfunction

    function automatic t_work fail_f(t_work x);
        x.st.halted = 1'b1;
        x.emit = 1'b1;
        x.res = '{payload_byte: 8'd0, event_res: EV_ERROR, object_start: 1'b0,
                  object_end: 1'b0};
        x.go = 1'b0;
        return x;
    endfunction

    function automatic t_work to_pad(t_work x);
        x.st.phase = (x.st.pkt_cnt >= x.st.pkt_len) ? PH_FIRST : PH_SKIP;
        return x;
    endfunction

    function automatic t_work end_segment(t_work x);
        if (x.st.segs_left != 6'd0) begin
            x.st.phase = PH_SEG_NUM;
        end else begin
            x = to_pad(x);
        end
        return x;
    endfunction

    function automatic t_work header_done(t_work x);
        logic [LEN_W-1:0] body;
        body = x.st.pkt_len - x.st.pad_len[LEN_W-1:0];
        if (x.st.pad_len >= 32'(x.st.pkt_len) || x.st.pkt_cnt > body) begin
            return fail_f(x);
        end
        x.st.size_left = body - x.st.pkt_cnt;
        x.st.pkts_done = x.st.pkts_done + 32'd1;
        x.go = 1'b0;
        if (x.st.segs_left == 6'd0) begin
            x = to_pad(x);
        end else begin
            x.st.phase = PH_SEG_NUM;
        end
        return x;
    endfunction

    function automatic t_work decide(t_work x, logic [31:0] frag);
        if (frag > 32'(x.st.size_left)) begin
            return fail_f(x);
        end
        x.go = 1'b0;
        x.st.frag_left = frag[LEN_W-1:0];
        if (x.st.seg_stream != i_cfg.audio_stream) begin
            x.st.mode = MODE_SKIP;
        end else if (x.st.repl_size == 32'd1) begin
            x.st.mode = MODE_SUBLEN;
        end else begin
            if (x.st.frag_off == 32'd0) begin
                if (x.st.media_size > 32'(i_cfg.max_frame_bytes)) begin
                    return fail_f(x);
                end
                x.st.obj_size   = x.st.media_size[15:0];
                x.st.obj_filled = 16'd0;
                x.st.obj_active = 1'b1;
            end
            if (!x.st.obj_active || x.st.frag_off != 32'(x.st.obj_filled) ||
                ({1'b0, x.st.frag_off} + {1'b0, frag}) > 33'(x.st.obj_size)) begin
                x.st.obj_active = 1'b0;
                x.st.mode = MODE_SKIP;
                x.emit = 1'b1;
                x.res = '{payload_byte: 8'd0, event_res: EV_DROP, object_start: 1'b0,
                          object_end: 1'b0};
            end else begin
                x.st.mode = MODE_FWD;
            end
        end
        if (x.st.frag_left == '0) begin
            // zero-length fragment can still close an object
            if (x.st.mode == MODE_FWD && x.st.obj_filled >= x.st.obj_size) begin
                x.st.obj_active = 1'b0;
            end
            x = end_segment(x);
        end else begin
            x.st.phase = PH_DATA;
        end
        return x;
    endfunction

    function automatic t_work after_repl(t_work x);
        if (x.st.flags[0]) begin
            x.go  = 1'b1;
            x.gph = PH_FRAGSZ;
        end else begin
            x = decide(x, 32'(x.st.size_left));
        end
        return x;
    endfunction

    function automatic t_work finish(t_work x, t_phase ph, logic [31:0] v);
        case (ph)
            PH_PLEN: begin
                if (v > 32'(MAX_PACKET_BYTES)) begin
                    x = fail_f(x);
                end else begin
                    x.st.pkt_len = v[LEN_W-1:0];
                    x.go = 1'b1;
                    x.gph = PH_SEQ;
                end
            end
            PH_SEQ: begin
                x.go = 1'b1;
                x.gph = PH_PAD;
            end
            PH_PAD: begin
                x.st.pad_len = v;
                x.go = 1'b1;
                x.gph = PH_SEND;
            end
            PH_SEND: begin
                x.go = 1'b1;
                x.gph = PH_DUR;
            end
            PH_DUR: begin
                if (x.st.flags[0]) begin
                    x.go = 1'b1;
                    x.gph = PH_SEGTYPE;
                end else begin
                    // single payload, no segment-type byte
                    x.st.seg_type  = 8'h80;
                    x.st.segs_left = 6'd1;
                    x = header_done(x);
                end
            end
            PH_OBJNUM: begin
                x.go = 1'b1;
                x.gph = PH_OFFSET;
            end
            PH_OFFSET: begin
                x.st.frag_off = v;
                x.go = 1'b1;
                x.gph = PH_REPLSZ;
            end
            PH_REPLSZ: begin
                x.st.repl_size  = v;
                x.st.media_size = 32'd0;
                x.st.hdr_used   = '0;
                if (v >= 32'd8) begin
                    x.go = 1'b1;
                    x.gph = PH_REPL;
                end else if (v == 32'd1) begin
                    x.st.frag_off = 32'd0;
                    x.go = 1'b1;
                    x.gph = PH_DELTA;
                end else if (v == 32'd0) begin
                    x = after_repl(x);
                end else begin
                    x = fail_f(x);
                end
            end
            PH_FRAGSZ: x = decide(x, v);
            default: ;
        endcase
        return x;
    endfunction

    function automatic t_work go_step(t_work x);
        t_phase     ph;
        logic [2:0] wd;
        ph = x.gph;
        x.go = 1'b0;
        x.st.phase = ph;
        if (is_field(ph)) begin
            wd = fwidth(x.st, ph);
            if (wd != 3'd0) begin
                x.st.fld_left = wd;
                x.st.fld_idx  = 2'd0;
                x.st.fld_val  = 32'd0;
            end else begin
                x = finish(x, ph,
                           (ph == PH_PLEN) ? 32'(i_cfg.default_packet_bytes) : 32'd0);
            end
        end
        return x;
    endfunction

    function automatic t_work data_in(t_work x, logic [7:0] b);
        x.st.size_left = x.st.size_left - 1'b1;
        x.st.frag_left = x.st.frag_left - 1'b1;
        case (x.st.mode)
            MODE_FWD: begin
                x.emit = 1'b1;
                x.res.payload_byte = b;
                x.res.event_res    = EV_PAYLOAD;
                x.res.object_start = (x.st.obj_filled == 16'd0);
                x.st.obj_filled = x.st.obj_filled + 16'd1;
                x.res.object_end = (x.st.obj_filled >= x.st.obj_size);
                if (x.res.object_end) begin
                    x.st.obj_active = 1'b0;
                end
            end
            MODE_SUBLEN: begin
                if (LEN_W'(b) > x.st.frag_left || 16'(b) > i_cfg.max_frame_bytes) begin
                    return fail_f(x);
                end
                if (b != 8'd0) begin
                    x.st.sub_left  = b;
                    x.st.sub_first = 1'b1;
                    x.st.mode      = MODE_SUB;
                end
            end
            MODE_SUB: begin
                x.emit = 1'b1;
                x.res.payload_byte = b;
                x.res.event_res    = EV_PAYLOAD;
                x.res.object_start = x.st.sub_first;
                x.st.sub_first = 1'b0;
                x.st.sub_left  = x.st.sub_left - 8'd1;
                x.res.object_end = (x.st.sub_left == 8'd0);
                if (x.st.sub_left == 8'd0) begin
                    x.st.mode = MODE_SUBLEN;
                end
            end
            default: ;
        endcase
        if (x.st.frag_left == '0) begin
            x = end_segment(x);
        end
        return x;
    endfunction

    always_comb begin
        w.st   = r_st;
        w.emit = 1'b0;
        w.res  = '0;
        w.go   = 1'b0;
        w.gph  = PH_FIRST;
        in_payload = (r_st.phase >= PH_SEG_NUM) && (r_st.phase <= PH_FRAGSZ);
        if (!r_st.halted) begin
            if (r_st.phase == PH_FIRST) begin
                if (i_cfg.total_packets != 32'd0 && r_st.pkts_done >= i_cfg.total_packets) begin
                    w.st.halted = 1'b1;
                    w.emit = 1'b1;
                    w.res.event_res = EV_END;
                end else begin
                    w.st.pkt_cnt = LEN_W'(1);
                    if (i_data_byte[7]) begin
                        // error-correction present; length only when bits 5-6 clear
                        w.st.size_left = (i_data_byte[6:5] == 2'd0) ?
                                         LEN_W'(i_data_byte[3:0]) : '0;
                        w.st.phase = (w.st.size_left != '0) ? PH_ECC : PH_FLAGS;
                    end else begin
                        w.st.flags = i_data_byte;
                        w.st.phase = PH_PROP;
                    end
                end
            end else begin
                w.st.pkt_cnt = r_st.pkt_cnt + 1'b1;
                if (in_payload && r_st.size_left == '0) begin
                    w = fail_f(w);
                end else begin
                    if (in_payload) begin
                        w.st.size_left = r_st.size_left - 1'b1;
                    end
                    case (r_st.phase)
                        PH_ECC: begin
                            w.st.size_left = r_st.size_left - 1'b1;
                            if (w.st.size_left == '0) begin
                                w.st.phase = PH_FLAGS;
                            end
                        end
                        PH_FLAGS: begin
                            w.st.flags = i_data_byte;
                            w.st.phase = PH_PROP;
                        end
                        PH_PROP: begin
                            w.st.prop = i_data_byte;
                            w.go  = 1'b1;
                            w.gph = PH_PLEN;
                        end
                        PH_SEGTYPE: begin
                            w.st.seg_type  = i_data_byte;
                            w.st.segs_left = i_data_byte[5:0];
                            w = header_done(w);
                        end
                        PH_SEG_NUM: begin
                            w.st.seg_stream = i_data_byte[6:0];
                            if (r_st.segs_left != 6'd0) begin
                                w.st.segs_left = r_st.segs_left - 6'd1;
                            end
                            w.go  = 1'b1;
                            w.gph = PH_OBJNUM;
                        end
                        PH_REPL: begin
                            // object size sits in the first four replicated bytes
                            if (r_st.hdr_used < (LEN_W+1)'(4)) begin
                                w.st.media_size = r_st.media_size |
                                    (32'(i_data_byte) << {r_st.hdr_used[1:0], 3'b000});
                            end
                            w.st.hdr_used = r_st.hdr_used + 1'b1;
                            if (32'(w.st.hdr_used) >= r_st.repl_size) begin
                                w = after_repl(w);
                            end
                        end
                        PH_DELTA: w = after_repl(w);
                        PH_DATA:  w = data_in(w, i_data_byte);
                        PH_SKIP: begin
                            if (w.st.pkt_cnt >= r_st.pkt_len) begin
                                w.st.phase = PH_FIRST;
                            end
                        end
                        default: begin
                            if (is_field(r_st.phase) && fwidth(r_st, r_st.phase) != 3'd0 &&
                                r_st.fld_left != 3'd0) begin
                                w.st.fld_val = r_st.fld_val |
                                    (32'(i_data_byte) << {r_st.fld_idx, 3'b000});
                                w.st.fld_idx  = r_st.fld_idx + 2'd1;
                                w.st.fld_left = r_st.fld_left - 3'd1;
                                if (w.st.fld_left == 3'd0) begin
                                    w = finish(w, r_st.phase, w.st.fld_val);
                                end
                            end else begin
                                w.st.phase = PH_FIRST;
                            end
                        end
                    endcase
                end
            end
            // zero-width fields fall through; at most four in a row
            for (int i = 0; i < 5; i++) begin
                if (w.go) begin
                    w = go_step(w);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_accept) begin
            r_st <= w.st;
        end
    end

    assign o_res_valid = i_accept & w.emit;
    assign o_res       = w.res;

endmodule

`default_nettype wire

// ----- sv/asfdpp_oreg.sv -----
// Output result register with stall handling.
`default_nettype none

module asfdpp_oreg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  asfdpp_pkg::t_result i_res,
    input  wire logic           i_ready,
    output logic                o_valid,
    output asfdpp_pkg::t_result o_res,
    output logic                o_can_take
);
    import asfdpp_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid    = r_valid;
    assign o_res      = r_res;
    assign o_can_take = !r_valid || i_ready;

endmodule

`default_nettype wire

// ----- sv/asf_data_packet_parser.sv -----
// Top level of the ASF data packet parser.
//
//  channel | dir | handshake                 | content
//  s       | in  | i_s_tvalid / o_s_tready   | tdata[7:0] data_byte
//  m       | out | o_m_tvalid / i_m_tready   | tdata payload_byte, tuser event/start,
//          |     |                           | tlast object_end
//  cfg     | in  | i_cfg_we                  | i_cfg_addr index, i_cfg_wdata value
//
// One byte per cycle while the output register can take a result; each byte is parsed in
// the cycle it is transferred and its result, if any, is in the output register on the next cycle.
// Input is taken while the output register is empty or being drained.
// Synchronous reset returns to the first-packet-byte phase; no clearing pass.
`default_nettype none

module asf_data_packet_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] payload_byte
    output logic [2:0]       o_m_tuser,   // [1:0] event_res, [2] object_start
    output logic             o_m_tlast,   // object_end
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);
    import asfdpp_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    core_valid;
    logic    accept;
    logic    can_take;

    assign accept     = i_s_tvalid & can_take;
    assign o_s_tready = can_take;

    asfdpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    asfdpp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_data_byte (i_s_tdata),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    asfdpp_oreg u_oreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (core_valid),
        .i_res      (core_res),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_res      (out_res),
        .o_can_take (can_take)
    );

    assign o_m_tdata = out_res.payload_byte;
    assign o_m_tuser = {out_res.object_start, out_res.event_res};
    assign o_m_tlast = out_res.object_end;

endmodule

`default_nettype wire

// ----- sv/asfdpp_chk.sv -----
// Port-level checker for the ASF data packet parser, with its bind.
`default_nettype none

module asfdpp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic [2:0]  o_m_tuser,
    input wire logic        o_m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // event transfers carry no byte and no marks
    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] != 2'd0 |->
            o_m_tdata == 8'd0 && !o_m_tlast && !o_m_tuser[2])
        else $error("event result with payload bits");

    // nothing follows a halting event
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser[1] |=> !o_m_tvalid)
        else $error("result after halt");

    // output free means input ready
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind asf_data_packet_parser asfdpp_chk u_asfdpp_chk (.*);

`default_nettype wire
